// ===== rtl/dsq_pkg.sv =====
// ----------------------------------------------------------------------------
// dsq_pkg
// Types and constants shared by the deadline sorted event queue and its cells.
// ----------------------------------------------------------------------------
package dsq_pkg;

  // field widths fixed by the request format
  localparam int unsigned DL_W       = 32;
  localparam int unsigned IN_TAG_W   = 16;

  // most entries that one dispatch request may pop
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned POP_CNT_W   = $clog2(MAX_RESULTS);

  // request and result codes
  localparam logic REQ_SCHEDULE = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_FIRED   = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCHED,
    ST_INSERT,
    ST_DISP
  } state_e;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_COMPARE,
    CELL_INSERT,
    CELL_POP
  } cell_op_e;

  // control bundle from the sequencer to the cells
  typedef struct packed {
    cell_op_e          op;
    logic [DL_W-1:0]   new_deadline;
    logic [DL_W-1:0]   now;
  } cell_ctrl_t;

endpackage

// ===== rtl/dsq_cell.sv =====
// ----------------------------------------------------------------------------
// dsq_cell
// One queue slot: holds a deadline and tag, compares against the broadcast
// deadline and shifts toward either neighbor on insert or pop.
// ----------------------------------------------------------------------------
module dsq_cell
  import dsq_pkg::*;
#(
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [TAG_BITS-1:0] new_tag_i,
  input  logic                left_valid_i,
  input  logic [DL_W-1:0]     left_deadline_i,
  input  logic [TAG_BITS-1:0] left_tag_i,
  input  logic                right_valid_i,
  input  logic [DL_W-1:0]     right_deadline_i,
  input  logic [TAG_BITS-1:0] right_tag_i,
  input  logic                found_i,
  output logic                found_o,
  output logic                valid_o,
  output logic [DL_W-1:0]     deadline_o,
  output logic [TAG_BITS-1:0] tag_o,
  output logic                arrived_o
);

  logic                valid_q, valid_d;
  logic                later_q, later_d;
  logic [DL_W-1:0]     deadline_q, deadline_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [DL_W-1:0]     diff_new;
  logic [DL_W-1:0]     diff_now;

  // wrap differences against the new deadline and the current time
  assign diff_new  = deadline_q - ctrl_i.new_deadline;
  assign diff_now  = ctrl_i.now - deadline_q;

  // an empty slot counts as later than anything
  assign later_d   = !valid_q || (!diff_new[DL_W-1] && (diff_new != '0));
  assign arrived_o = valid_q && !diff_now[DL_W-1];

  // first later slot takes the new entry, all after it shift right
  assign found_o   = found_i || later_q;

  // next slot contents
  always_comb begin
    valid_d    = valid_q;
    deadline_d = deadline_q;
    tag_d      = tag_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (found_i) begin
          valid_d    = left_valid_i;
          deadline_d = left_deadline_i;
          tag_d      = left_tag_i;
        end else if (later_q) begin
          valid_d    = 1'b1;
          deadline_d = ctrl_i.new_deadline;
          tag_d      = new_tag_i;
        end
      end
      CELL_POP: begin
        valid_d    = right_valid_i;
        deadline_d = right_deadline_i;
        tag_d      = right_tag_i;
      end
      default: begin
      end
    endcase
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      later_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.op == CELL_COMPARE) begin
        later_q <= later_d;
      end
    end
  end

  // payload flops
  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    tag_q      <= tag_d;
  end

  assign valid_o    = valid_q;
  assign deadline_o = deadline_q;
  assign tag_o      = tag_q;

endmodule

// ===== rtl/deadline_sorted_event_queue_top.sv =====
// ----------------------------------------------------------------------------
// deadline_sorted_event_queue_top
// Timed event queue kept in deadline order in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage
//   A request is taken at a clock edge with start_i high and busy_o low.
//   req_type_i 0 schedules event_tag_i at current_time_i + delay_i (mod 2^32)
//   and answers one status result. req_type_i 1 pops, in order, each front
//   entry whose deadline has arrived and emits one fired result per entry,
//   at most 16 per request, last_o marking the final one. A dispatch with
//   nothing arrived returns no result.
//   Results appear for one cycle each with result_valid_o high; the receiver
//   cannot stall them.
//   Timing: a schedule keeps busy_o high through the compare, then the shift
//   into place, or only through its first state when the queue is full; its
//   status shows in the cycle after. A dispatch keeps busy_o high while it
//   pops, one pop per cycle, and for its first state alone when nothing has
//   arrived; each fired result shows in the cycle after its pop. The cell
//   compare and the single-slot shift of the chain set this sequence.
//   Reset empties the queue: all slot valid bits clear, no result pending.
// ----------------------------------------------------------------------------
module deadline_sorted_event_queue_top
  import dsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                req_type_i,
  input  logic [DL_W-1:0]     current_time_i,
  input  logic [DL_W-1:0]     delay_i,
  input  logic [IN_TAG_W-1:0] event_tag_i,
  output logic                result_valid_o,
  output logic                result_kind_o,
  output logic                status_o,
  output logic [IN_TAG_W-1:0] fired_tag_o,
  output logic                last_o
);

  state_e                state_q, state_d;
  logic [DL_W-1:0]       now_q;
  logic [DL_W-1:0]       deadline_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [TAG_BITS-1:0]   tag_in;
  logic [POP_CNT_W-1:0]  pop_cnt_q, pop_cnt_d;
  logic                  accept;
  cell_ctrl_t            ctrl;

  logic                  res_valid_q, res_valid_d;
  logic                  res_kind_q, res_kind_d;
  logic                  res_status_q, res_status_d;
  logic                  res_last_q, res_last_d;
  logic [TAG_BITS-1:0]   res_tag_q, res_tag_d;

  logic                  cell_valid [QUEUE_DEPTH];
  logic [DL_W-1:0]       cell_dl    [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]   cell_tag   [QUEUE_DEPTH];
  logic                  cell_arr   [QUEUE_DEPTH];
  logic                  found      [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0] valid_vec;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // request tag resized to the stored width
  for (genvar b = 0; b < TAG_BITS; b++) begin : g_tag_in
    if (b < IN_TAG_W) begin : g_bit
      assign tag_in[b] = event_tag_i[b];
    end else begin : g_zero
      assign tag_in[b] = 1'b0;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q      <= current_time_i;
      deadline_q <= current_time_i + delay_i;
      tag_q      <= tag_in;
    end
  end

  // cell chain
  assign found[0] = 1'b0;
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                lv, rv;
    logic [DL_W-1:0]     ld, rd;
    logic [TAG_BITS-1:0] lt, rt;
    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign ld = '0;
      assign lt = '0;
    end else begin : g_left
      assign lv = cell_valid[i-1];
      assign ld = cell_dl[i-1];
      assign lt = cell_tag[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rd = '0;
      assign rt = '0;
    end else begin : g_right
      assign rv = cell_valid[i+1];
      assign rd = cell_dl[i+1];
      assign rt = cell_tag[i+1];
    end
    dsq_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctrl_i          (ctrl),
      .new_tag_i       (tag_q),
      .left_valid_i    (lv),
      .left_deadline_i (ld),
      .left_tag_i      (lt),
      .right_valid_i   (rv),
      .right_deadline_i(rd),
      .right_tag_i     (rt),
      .found_i         (found[i]),
      .found_o         (found[i+1]),
      .valid_o         (cell_valid[i]),
      .deadline_o      (cell_dl[i]),
      .tag_o           (cell_tag[i]),
      .arrived_o       (cell_arr[i])
    );
    assign valid_vec[i] = cell_valid[i];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (req_type_i == REQ_DISPATCH) ? ST_DISP : ST_SCHED;
        end
      end
      ST_SCHED: begin
        state_d = cell_valid[QUEUE_DEPTH-1] ? ST_IDLE : ST_INSERT;
      end
      ST_INSERT: begin
        state_d = ST_IDLE;
      end
      ST_DISP: begin
        if (!cell_arr[0] || !cell_arr[1] ||
            (pop_cnt_q == POP_CNT_W'(MAX_RESULTS - 1))) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl.op           = CELL_HOLD;
    ctrl.new_deadline = deadline_q;
    ctrl.now          = now_q;
    pop_cnt_d         = pop_cnt_q;
    res_valid_d       = 1'b0;
    res_kind_d        = KIND_STATUS;
    res_status_d      = STATUS_OK;
    res_last_d        = 1'b1;
    res_tag_d         = '0;
    case (state_q)
      ST_IDLE: begin
        pop_cnt_d = '0;
      end
      ST_SCHED: begin
        if (cell_valid[QUEUE_DEPTH-1]) begin
          res_valid_d  = 1'b1;
          res_status_d = STATUS_FULL;
        end else begin
          ctrl.op = CELL_COMPARE;
        end
      end
      ST_INSERT: begin
        ctrl.op     = CELL_INSERT;
        res_valid_d = 1'b1;
      end
      ST_DISP: begin
        if (cell_arr[0]) begin
          ctrl.op     = CELL_POP;
          pop_cnt_d   = pop_cnt_q + 1'b1;
          res_valid_d = 1'b1;
          res_kind_d  = KIND_FIRED;
          res_tag_d   = cell_tag[0];
          res_last_d  = !cell_arr[1] || (pop_cnt_q == POP_CNT_W'(MAX_RESULTS - 1));
        end
      end
      default: begin
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pop_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pop_cnt_q   <= pop_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_kind_q   <= res_kind_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
    res_tag_q    <= res_tag_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_kind_o  = res_kind_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

  // emitted tag resized to the port width
  for (genvar b = 0; b < IN_TAG_W; b++) begin : g_tag_out
    if (b < TAG_BITS) begin : g_bit
      assign fired_tag_o[b] = res_tag_q[b];
    end else begin : g_zero
      assign fired_tag_o[b] = 1'b0;
    end
  end

  // occupied slots always form a contiguous run from the head
  a_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("slot valid bits not contiguous");

  // a fired result only follows a pop in the dispatch state
  a_fired_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_kind_q == KIND_FIRED)) |-> $past(state_q == ST_DISP))
    else $error("fired result outside dispatch");

  // queue full answered only when the tail slot was occupied
  a_full_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_status_q == STATUS_FULL)) |-> $past(cell_valid[QUEUE_DEPTH-1]))
    else $error("queue full reported with free slot");

  // a status result is always the last of its request
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_kind_q == KIND_STATUS)) |-> res_last_q)
    else $error("status result without last mark");

  // leaving dispatch with a pop means the final result carries last
  a_disp_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DISP) && (state_d == ST_IDLE) && cell_arr[0]) |=> res_last_q)
    else $error("dispatch ended without last mark");

endmodule
